// ----- hdl/aml_sts_pkg.sv -----
package aml_sts_pkg;

	// Bytes one candidate can touch, from the first prefix byte to the last integer byte.
	localparam int SPAN = 30;
	localparam int INT_SPAN = 9;

	// Window offsets relative to the oldest cell, with the candidate name at offset two.
	localparam int CAND_OFF = 2;
	localparam int PKG_OFF = CAND_OFF + 4;
	localparam int LEAD_OFF = PKG_OFF + 1;
	localparam int INT1_BASE = LEAD_OFF + 2;
	localparam int MORE_FROM = PKG_OFF + 1;

	localparam logic [7:0] OP_NAME = 8'h08;
	localparam logic [7:0] OP_ROOT = 8'h5C;
	localparam logic [7:0] OP_PKG = 8'h12;
	localparam logic [7:0] OP_ZERO = 8'h00;
	localparam logic [7:0] OP_ONE = 8'h01;
	localparam logic [7:0] OP_ONES = 8'hFF;
	localparam logic [7:0] OP_BYTE = 8'h0A;
	localparam logic [7:0] OP_WORD = 8'h0B;
	localparam logic [7:0] OP_DWORD = 8'h0C;
	localparam logic [7:0] OP_QWORD = 8'h0E;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_5 = 8'h35;

	localparam logic [2:0] LOW3_ONES = 3'h7;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] type_a;
		logic [2:0] type_b;
	} match_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] low3;
		logic [3:0] len;
	} int_res_t;

endpackage

// ----- hdl/aml_sts_in_if.sv -----
interface aml_sts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/aml_sts_out_if.sv -----
interface aml_sts_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [2:0] sleep_type_a;
	logic [2:0] sleep_type_b;

	modport source (output valid, output found, output sleep_type_a, output sleep_type_b,
		input ready);
	modport sink (input valid, input found, input sleep_type_a, input sleep_type_b,
		output ready);
endinterface

// ----- hdl/aml_sts_cell.sv -----
module aml_sts_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aml_sts_pkg::cell_ctl_t ctl,
	input  logic [7:0]            nb_data,
	input  logic                  nb_vld,
	output logic [7:0]            data,
	output logic                  vld
);

	logic [7:0] data_q;
	logic       vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= nb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= nb_data;
		end
	end

	assign data = data_q;
	assign vld = vld_q;

endmodule

// ----- hdl/aml_sts_match.sv -----
module aml_sts_match (
	input  logic [aml_sts_pkg::SPAN-1:0][7:0] win_data,
	input  logic [aml_sts_pkg::SPAN-1:0]      win_vld,
	output aml_sts_pkg::match_t               res
);

	localparam int IDXW = $clog2(aml_sts_pkg::SPAN);

	function automatic aml_sts_pkg::int_res_t take_int(
		input logic [aml_sts_pkg::INT_SPAN-1:0][7:0] d,
		input logic [aml_sts_pkg::INT_SPAN-1:0]      v
	);
		aml_sts_pkg::int_res_t r;
		r = '0;
		if (v[0]) begin
			unique case (d[0])
				aml_sts_pkg::OP_ZERO: begin
					r.ok = 1'b1;
					r.low3 = 3'd0;
					r.len = 4'd1;
				end
				aml_sts_pkg::OP_ONE: begin
					r.ok = 1'b1;
					r.low3 = 3'd1;
					r.len = 4'd1;
				end
				aml_sts_pkg::OP_ONES: begin
					r.ok = 1'b1;
					r.low3 = aml_sts_pkg::LOW3_ONES;
					r.len = 4'd1;
				end
				aml_sts_pkg::OP_BYTE: begin
					r.ok = v[1];
					r.low3 = d[1][2:0];
					r.len = 4'd2;
				end
				aml_sts_pkg::OP_WORD: begin
					r.ok = v[2];
					r.low3 = d[1][2:0];
					r.len = 4'd3;
				end
				aml_sts_pkg::OP_DWORD: begin
					r.ok = v[4];
					r.low3 = d[1][2:0];
					r.len = 4'd5;
				end
				aml_sts_pkg::OP_QWORD: begin
					r.ok = v[8];
					r.low3 = d[1][2:0];
					r.len = 4'd9;
				end
				default: begin
					r = '0;
				end
			endcase
		end
		return r;
	endfunction

	logic [1:0]                                follow;
	logic [IDXW-1:0]                           lead_end;
	logic [IDXW-1:0]                           p1;
	logic [IDXW-1:0]                           p2;
	logic [aml_sts_pkg::INT_SPAN-1:0][7:0]     s1_data;
	logic [aml_sts_pkg::INT_SPAN-1:0]          s1_vld;
	logic [aml_sts_pkg::INT_SPAN-1:0][7:0]     s2_data;
	logic [aml_sts_pkg::INT_SPAN-1:0]          s2_vld;
	aml_sts_pkg::int_res_t                     r1;
	aml_sts_pkg::int_res_t                     r2;
	logic                                      prefix_ok;
	logic                                      name_ok;
	logic                                      len_ok;

	always_comb begin
		follow = win_data[aml_sts_pkg::LEAD_OFF][7:6];
		lead_end = IDXW'(aml_sts_pkg::LEAD_OFF) + IDXW'(follow);
		p1 = IDXW'(aml_sts_pkg::INT1_BASE) + IDXW'(follow);
		for (int j = 0; j < aml_sts_pkg::INT_SPAN; j++) begin
			s1_data[j] = win_data[p1 + IDXW'(j)];
			s1_vld[j] = win_vld[p1 + IDXW'(j)];
		end
		r1 = take_int(s1_data, s1_vld);
		p2 = p1 + IDXW'(r1.len);
		for (int j = 0; j < aml_sts_pkg::INT_SPAN; j++) begin
			s2_data[j] = win_data[p2 + IDXW'(j)];
			s2_vld[j] = win_vld[p2 + IDXW'(j)];
		end
		r2 = take_int(s2_data, s2_vld);

		prefix_ok = (win_vld[aml_sts_pkg::CAND_OFF-1]
				&& win_data[aml_sts_pkg::CAND_OFF-1] == aml_sts_pkg::OP_NAME)
			|| (win_vld[aml_sts_pkg::CAND_OFF-2]
				&& win_data[aml_sts_pkg::CAND_OFF-2] == aml_sts_pkg::OP_NAME
				&& win_vld[aml_sts_pkg::CAND_OFF-1]
				&& win_data[aml_sts_pkg::CAND_OFF-1] == aml_sts_pkg::OP_ROOT);
		name_ok = win_vld[aml_sts_pkg::CAND_OFF] && win_vld[aml_sts_pkg::PKG_OFF]
			&& win_data[aml_sts_pkg::CAND_OFF] == aml_sts_pkg::CH_UNDER
			&& win_data[aml_sts_pkg::CAND_OFF+1] == aml_sts_pkg::CH_S
			&& win_data[aml_sts_pkg::CAND_OFF+2] == aml_sts_pkg::CH_5
			&& win_data[aml_sts_pkg::CAND_OFF+3] == aml_sts_pkg::CH_UNDER
			&& win_data[aml_sts_pkg::PKG_OFF] == aml_sts_pkg::OP_PKG;
		len_ok = win_vld[aml_sts_pkg::LEAD_OFF] && win_vld[lead_end]
			&& win_vld[lead_end + IDXW'(1)];

		res.hit = prefix_ok && name_ok && len_ok && r1.ok && r2.ok;
		res.type_a = r1.low3;
		res.type_b = r2.low3;
	end

endmodule

// ----- hdl/aml_sleep_type_scanner_unit.sv -----
// AML sleep-type scanner.
// The body channel takes a table's AML body one item per cycle while ready is high,
// with last_byte set on its final item. The result channel gives one item per body:
// found with the two sleep types of the first _S5_ package, or found=0 if none parsed.
// Bytes move through a row of WINDOW_BYTES cells; every shift brings the next start
// position to a fixed cell, where one candidate is checked per cycle of shifting.
// A match inside the body reaches the result channel once the item that completes it
// is in the row and the result is registered; the rest of that body is still taken
// at full rate and dropped. After the final item the row keeps shifting empty cells
// to check the remaining positions, with body.ready low; the next body is taken once
// the result for this one is loaded.
// Throughput is one item per cycle within a body while no result stalls the row.
// The result sits in an output register: while the receiver stalls, body items keep
// flowing unless a new result would need that register, and then the row holds.
// Reset empties the row and drops any result not yet taken.
module aml_sleep_type_scanner_unit #(
	parameter int WINDOW_BYTES = 30
) (
	input logic          clk,
	input logic          arst_n,
	aml_sts_in_if.sink   body,
	aml_sts_out_if.source result
);

	logic [WINDOW_BYTES-1:0][7:0] cell_data;
	logic [WINDOW_BYTES-1:0]      cell_vld;
	aml_sts_pkg::cell_ctl_t       ctl;
	aml_sts_pkg::match_t          match;

	logic       eval_q;
	logic       end_q;
	logic       done_q;
	logic       out_valid_q;
	logic       found_q;
	logic [2:0] type_a_q;
	logic [2:0] type_b_q;

	logic       eval_d;
	logic       end_d;
	logic       done_d;
	logic       bubble;
	logic [7:0] tail_data;
	logic       tail_vld;
	logic       no_more;
	logic       eval_hit;
	logic       produce;
	logic       out_can;
	logic       stall;
	logic       accept;
	logic       eff_done;
	logic       load_out;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_BYTES; gi++) begin : g_cell
			if (gi == WINDOW_BYTES - 1) begin : g_tail
				aml_sts_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.nb_data (tail_data),
					.nb_vld  (tail_vld),
					.data    (cell_data[gi]),
					.vld     (cell_vld[gi])
				);
			end else begin : g_body
				aml_sts_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.nb_data (cell_data[gi+1]),
					.nb_vld  (cell_vld[gi+1]),
					.data    (cell_data[gi]),
					.vld     (cell_vld[gi])
				);
			end
		end
	endgenerate

	aml_sts_match u_match (
		.win_data (cell_data[aml_sts_pkg::SPAN-1:0]),
		.win_vld  (cell_vld[aml_sts_pkg::SPAN-1:0]),
		.res      (match)
	);

	assign no_more = !(|cell_vld[WINDOW_BYTES-1:aml_sts_pkg::MORE_FROM]);
	assign eval_hit = eval_q && match.hit;
	assign produce = eval_hit || (eval_q && end_q && no_more);
	assign out_can = !out_valid_q || result.ready;
	assign stall = produce && !out_can;
	assign body.ready = !end_q && !stall;
	assign accept = body.valid && body.ready;
	assign eff_done = done_q || eval_hit;
	assign load_out = produce && !stall;
	assign tail_data = bubble ? 8'h00 : body.data_byte;
	assign tail_vld = !bubble;

	always_comb begin
		ctl = '0;
		bubble = 1'b0;
		eval_d = eval_q;
		end_d = end_q;
		done_d = done_q;
		if (stall) begin
			ctl = '0;
		end else if (end_q) begin
			if (produce) begin
				ctl.clear = 1'b1;
				eval_d = 1'b0;
				end_d = 1'b0;
				done_d = 1'b0;
			end else begin
				ctl.shift = 1'b1;
				bubble = 1'b1;
				eval_d = 1'b1;
			end
		end else begin
			eval_d = 1'b0;
			if (produce) begin
				done_d = 1'b1;
			end
			if (accept) begin
				if (eff_done) begin
					if (body.last_byte) begin
						ctl.clear = 1'b1;
						done_d = 1'b0;
					end
				end else begin
					ctl.shift = 1'b1;
					eval_d = 1'b1;
					end_d = body.last_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_q <= 1'b0;
			end_q <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			eval_q <= eval_d;
			end_q <= end_d;
			done_q <= done_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= match.hit;
			type_a_q <= match.hit ? match.type_a : 3'd0;
			type_b_q <= match.hit ? match.type_b : 3'd0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.found = found_q;
	assign result.sleep_type_a = type_a_q;
	assign result.sleep_type_b = type_b_q;

	a_end_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		end_q |-> !body.ready)
		else $error("Body item taken while the end of a body is being scanned.");

	a_done_end_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && end_q))
		else $error("End scan running after a match was already given.");

	a_end_evaluates: assert property (@(posedge clk) disable iff (!arst_n)
		end_q |-> eval_q)
		else $error("End scan cycle without a fresh candidate.");

	a_done_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !ctl.shift)
		else $error("Window shifted after a match was given.");

	a_miss_zero_types: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |->
			(result.sleep_type_a == 3'd0 && result.sleep_type_b == 3'd0))
		else $error("Nonzero sleep types on a result without a match.");

endmodule
